>>> rtl/core/stsma_pkg.sv
// Package for the sparse triplet sort/merge/add block.
// Holds list geometry, item codes, payload structs and the control state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stsma_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // item kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // one stored triplet; {row, col} is the sort key
   typedef struct packed {
      logic        [15:0] row;
      logic        [15:0] col;
      logic signed [31:0] value;
   } entry_type;

   typedef struct packed {
      logic        [1:0]  kind;
      logic        [15:0] row_index;
      logic        [15:0] col_index;
      logic signed [31:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      logic        [15:0] out_row;
      logic        [15:0] out_col;
      logic signed [31:0] out_value;
      logic               is_last;
      logic               load_overflow;
   } rsp_payload_type;

   // which heads the merge consumes
   typedef struct packed {
      logic take_a;
      logic take_b;
   } pick_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_MRG_RD,
      ST_MRG_CMP
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/stsma_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on stsma_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none
interface stsma_req_if;
   import stsma_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stsma_rsp_if;
   import stsma_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sparse_triplet_sort_merge_add.sv
// Top level of the sparse triplet sort/merge/add block.
// Depends on stsma_pkg, stsma_if and stsma_pick.
//
// Load transactions append a (row, col, value) triplet to list A or B; each
// list lives in a 32-entry single-write memory with registered read data and
// is kept in row-major order by insertion at load time (stable: a new entry
// goes after equal keys). A load into an empty or a full list is handled in
// the idle state; any other load moves each stored entry with a larger key up
// one slot (read, then compare and write back) and then writes the new entry.
// A start transaction reads both heads, then compares and emits, once per
// result, and holds on any stall on the response channel; equal coordinates
// give one saturated sum. After the run both lists and the overflow flag are
// cleared. Loads into a full list are dropped and flagged on every result of
// the next run. No transaction is accepted while a load insertion or a merge
// run is in progress.
`timescale 1ns / 1ps
`default_nettype none
module sparse_triplet_sort_merge_add (
   input  wire         clock,
   input  wire         reset,
   stsma_req_if.sink   req_ch,
   stsma_rsp_if.source rsp_ch
);
   import stsma_pkg::*;

   // list memories
   entry_type mem_a [LIST_DEPTH];
   entry_type mem_b [LIST_DEPTH];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]  cnt_b_ff, cnt_b_in;
   logic              ovf_ff, ovf_in;
   logic              sel_b_ff, sel_b_in;
   entry_type         hold_ff, hold_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  idx_a_ff, idx_a_in;
   logic [CNT_W-1:0]  idx_b_ff, idx_b_in;
   entry_type         rd_a_ff, rd_b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              wr_a_en, wr_b_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

   logic              req_fire;
   logic              load_b;
   logic [CNT_W-1:0]  load_cnt;
   entry_type         req_entry;
   entry_type         ins_data;
   logic [CNT_W-1:0]  pos_dec;
   logic              shift_up;
   logic              has_a, has_b;
   pick_type          pick;
   entry_type         merged;
   logic              emit_ok;
   logic [CNT_W-1:0]  idx_a_next, idx_b_next;
   logic              run_last;

   // request decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign load_b       = (req_ch.payload.kind == KIND_LOAD_B);
   assign load_cnt     = load_b ? cnt_b_ff : cnt_a_ff;
   assign req_entry    = '{row: req_ch.payload.row_index,
                           col: req_ch.payload.col_index,
                           value: req_ch.payload.entry_value};

   // insertion compare
   assign ins_data = sel_b_ff ? rd_b_ff : rd_a_ff;
   assign pos_dec  = pos_ff - CNT_W'(1);
   assign shift_up = {ins_data.row, ins_data.col} > {hold_ff.row, hold_ff.col};

   // merge heads
   assign has_a      = idx_a_ff < cnt_a_ff;
   assign has_b      = idx_b_ff < cnt_b_ff;
   assign emit_ok    = !rsp_valid_ff || rsp_ch.ready;
   assign idx_a_next = idx_a_ff + CNT_W'(pick.take_a);
   assign idx_b_next = idx_b_ff + CNT_W'(pick.take_b);
   assign run_last   = (idx_a_next == cnt_a_ff) && (idx_b_next == cnt_b_ff);

   stsma_pick u_pick (
      .has_a  (has_a),
      .has_b  (has_b),
      .head_a (rd_a_ff),
      .head_b (rd_b_ff),
      .pick   (pick),
      .result (merged)
   );

   // read addresses
   always_comb begin
      if (state_ff == ST_INS_RD) begin
         rd_addr_a = pos_dec[ADDR_W-1:0];
         rd_addr_b = pos_dec[ADDR_W-1:0];
      end else begin
         rd_addr_a = idx_a_ff[ADDR_W-1:0];
         rd_addr_b = idx_b_ff[ADDR_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_ch.payload.kind == KIND_LOAD_A || req_ch.payload.kind == KIND_LOAD_B)
                   && load_cnt != CNT_W'(LIST_DEPTH) && load_cnt != '0) begin
                  state_in = ST_INS_RD;
               end else if (req_ch.payload.kind == KIND_START
                            && (cnt_a_ff != '0 || cnt_b_ff != '0)) begin
                  state_in = ST_MRG_RD;
               end
            end
         end
         ST_INS_RD:  state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (!shift_up) begin
               state_in = ST_IDLE;
            end else if (pos_dec == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_INS_PUT: state_in = ST_IDLE;
         ST_MRG_RD:  state_in = ST_MRG_CMP;
         ST_MRG_CMP: begin
            if (emit_ok) begin
               state_in = run_last ? ST_IDLE : ST_MRG_RD;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory write control
   always_comb begin
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ovf_in       = ovf_ff;
      sel_b_in     = sel_b_ff;
      hold_in      = hold_ff;
      pos_in       = pos_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      wr_a_en      = 1'b0;
      wr_b_en      = 1'b0;
      wr_addr      = pos_ff[ADDR_W-1:0];
      wr_data      = hold_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.payload.kind)
                  KIND_LOAD_A, KIND_LOAD_B: begin
                     if (load_cnt == CNT_W'(LIST_DEPTH)) begin
                        ovf_in = 1'b1;
                     end else if (load_cnt == '0) begin
                        // empty list: write straight to slot 0
                        wr_a_en = !load_b;
                        wr_b_en = load_b;
                        wr_addr = '0;
                        wr_data = req_entry;
                        if (load_b) begin
                           cnt_b_in = CNT_W'(1);
                        end else begin
                           cnt_a_in = CNT_W'(1);
                        end
                     end else begin
                        hold_in  = req_entry;
                        sel_b_in = load_b;
                        pos_in   = load_cnt;
                     end
                  end
                  KIND_START: begin
                     idx_a_in = '0;
                     idx_b_in = '0;
                     if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                        ovf_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_CMP: begin
            wr_a_en = !sel_b_ff;
            wr_b_en = sel_b_ff;
            if (shift_up) begin
               // move the larger entry up one slot
               wr_data = ins_data;
               pos_in  = pos_dec;
            end else begin
               if (sel_b_ff) begin
                  cnt_b_in = cnt_b_ff + CNT_W'(1);
               end else begin
                  cnt_a_in = cnt_a_ff + CNT_W'(1);
               end
            end
         end
         ST_INS_PUT: begin
            wr_a_en = !sel_b_ff;
            wr_b_en = sel_b_ff;
            if (sel_b_ff) begin
               cnt_b_in = cnt_b_ff + CNT_W'(1);
            end else begin
               cnt_a_in = cnt_a_ff + CNT_W'(1);
            end
         end
         ST_MRG_CMP: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_row: merged.row, out_col: merged.col,
                                out_value: merged.value, is_last: run_last,
                                load_overflow: ovf_ff};
               idx_a_in     = idx_a_next;
               idx_b_in     = idx_b_next;
               if (run_last) begin
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sel_b_ff    <= sel_b_in;
      hold_ff     <= hold_in;
      pos_ff      <= pos_in;
      idx_a_ff    <= idx_a_in;
      idx_b_ff    <= idx_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   // list memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/stsma_pick.sv
// Merge decision: compares the heads of both sorted lists and forms the
// emitted entry, summing equal coordinates with 32-bit saturation. Uses stsma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsma_pick (
   input  wire                  has_a,
   input  wire                  has_b,
   input  stsma_pkg::entry_type head_a,
   input  stsma_pkg::entry_type head_b,
   output stsma_pkg::pick_type  pick,
   output stsma_pkg::entry_type result
);
   import stsma_pkg::*;

   logic [31:0]        key_a;
   logic [31:0]        key_b;
   logic signed [32:0] sum;
   logic signed [31:0] sum_sat;

   assign key_a = {head_a.row, head_a.col};
   assign key_b = {head_b.row, head_b.col};

   // saturating sum of two Q16.16 values
   assign sum = 33'(head_a.value) + 33'(head_b.value);
   always_comb begin
      if (sum[32] != sum[31]) begin
         sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sum_sat = sum[31:0];
      end
   end

   // smaller key goes first, equal keys consume both heads
   always_comb begin
      pick.take_a = has_a && (!has_b || key_a <= key_b);
      pick.take_b = has_b && (!has_a || key_b <= key_a);
      if (pick.take_a && pick.take_b) begin
         result = '{row: head_a.row, col: head_a.col, value: sum_sat};
      end else if (pick.take_a) begin
         result = head_a;
      end else begin
         result = head_b;
      end
   end

endmodule
`default_nettype wire

>>> dv/stsma_tb_if.sv
// Testbench-side note: the channel interfaces come from the RTL file stsma_if.sv.
// This file holds shared testbench constants for the merge checker; depends on stsma_pkg.
`timescale 1ns / 1ps
package stsma_tb_pkg;
   import stsma_pkg::*;
   // kind code that the block ignores
   localparam logic [1:0] KIND_IGNORED = 2'd3;
   // idling phases
   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;
endpackage

>>> dv/tb_sparse_triplet_sort_merge_add.sv
// Testbench for sparse_triplet_sort_merge_add: random and directed load/start
// transactions, a sorting/merging predictor, and a whole-payload response check.
// Depends on stsma_pkg, stsma_tb_pkg, stsma_if and the RTL top level.
`timescale 1ns / 1ps
module tb_sparse_triplet_sort_merge_add;
   import stsma_pkg::*;
   import stsma_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stsma_req_if req_ch();
   stsma_rsp_if rsp_ch();

   sparse_triplet_sort_merge_add DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // pending request transactions and expected merged entries
   req_payload_type pending_reqs[$];
   rsp_payload_type merged_expect[$];

   // predictor state
   entry_type list_a[$];
   entry_type list_b[$];
   logic      dropped_load;

   phase_type phase = PH_FREE;
   int        hold_off_cycles = 0;
   bit        drain_pause = 1'b0;
   int        mismatches = 0;
   int        idle_cycles = 0;
   bit        req_taken = 1'b0;

   // stable insertion into row-major order
   function automatic void insert_sorted(ref entry_type lst[$], input entry_type e);
      int pos;
      pos = lst.size();
      while (pos > 0 && {lst[pos-1].row, lst[pos-1].col} > {e.row, e.col})
         pos--;
      lst.insert(pos, e);
   endfunction

   function automatic logic signed [31:0] sat_sum(logic signed [31:0] x,
                                                  logic signed [31:0] y);
      logic signed [32:0] s;
      s = 33'(x) + 33'(y);
      if (s > 33'sd2147483647) return 32'sh7fffffff;
      if (s < -33'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic void push_merged(logic [15:0] r, logic [15:0] c,
                                       logic signed [31:0] v);
      rsp_payload_type p;
      p.out_row = r;
      p.out_col = c;
      p.out_value = v;
      p.is_last = 1'b0;
      p.load_overflow = dropped_load;
      merged_expect.push_back(p);
   endfunction

   // model one accepted transaction
   function automatic void predict_merge(req_payload_type t);
      entry_type e;
      int i, j, n0;
      e.row = t.row_index;
      e.col = t.col_index;
      e.value = t.entry_value;
      case (t.kind)
         KIND_LOAD_A: begin
            if (list_a.size() >= LIST_DEPTH) dropped_load = 1'b1;
            else insert_sorted(list_a, e);
         end
         KIND_LOAD_B: begin
            if (list_b.size() >= LIST_DEPTH) dropped_load = 1'b1;
            else insert_sorted(list_b, e);
         end
         KIND_START: begin
            i = 0;
            j = 0;
            n0 = merged_expect.size();
            while (i < list_a.size() && j < list_b.size()) begin
               if ({list_a[i].row, list_a[i].col} > {list_b[j].row, list_b[j].col}) begin
                  push_merged(list_b[j].row, list_b[j].col, list_b[j].value);
                  j++;
               end else if ({list_a[i].row, list_a[i].col} ==
                            {list_b[j].row, list_b[j].col}) begin
                  push_merged(list_a[i].row, list_a[i].col,
                              sat_sum(list_a[i].value, list_b[j].value));
                  i++;
                  j++;
               end else begin
                  push_merged(list_a[i].row, list_a[i].col, list_a[i].value);
                  i++;
               end
            end
            for (; i < list_a.size(); i++)
               push_merged(list_a[i].row, list_a[i].col, list_a[i].value);
            for (; j < list_b.size(); j++)
               push_merged(list_b[j].row, list_b[j].col, list_b[j].value);
            if (merged_expect.size() > n0)
               merged_expect[merged_expect.size()-1].is_last = 1'b1;
            list_a.delete();
            list_b.delete();
            dropped_load = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic req_payload_type make_req(logic [1:0] k, logic [15:0] r,
                                                logic [15:0] c, logic [31:0] v);
      req_payload_type t;
      t.kind = k;
      t.row_index = r;
      t.col_index = c;
      t.entry_value = v;
      return t;
   endfunction

   // small coordinate space so that duplicates and equal keys are common
   function automatic req_payload_type rand_load(logic [1:0] k);
      logic [15:0] r, c;
      logic [31:0] v;
      if ($urandom_range(0, 3) == 0) begin
         r = 16'($urandom);
         c = 16'($urandom);
      end else begin
         r = 16'($urandom_range(0, 5));
         c = 16'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 5))
         0: v = 32'h7fff0000 + $urandom_range(0, 16'hffff);
         1: v = 32'h80000000 + $urandom_range(0, 16'hffff);
         default: v = $urandom;
      endcase
      return make_req(k, r, c, v);
   endfunction

   // transaction accepted at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
   end

   // driver: inputs change at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (drain_pause && merged_expect.size() != 0) begin
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !((phase == PH_SEND_IDLE &&
                         $urandom_range(0, 99) < 77) ||
                        (phase == PH_BOTH &&
                         $urandom_range(0, 99) < 26))) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_reqs.pop_front();
            drain_pause <= 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver readiness, with its own long hold-off counter
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ch.ready <= !((phase == PH_RECV_STALL && $urandom_range(0, 99) < 77) ||
                           (phase == PH_BOTH && $urandom_range(0, 99) < 26));
      end
   end

   // monitor: sample at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            predict_merge(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (merged_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: %p", rsp_ch.payload);
            end else begin
               if (rsp_ch.payload !== merged_expect[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", merged_expect[0],
                              rsp_ch.payload);
               end
               void'(merged_expect.pop_front());
            end
         end
         // watchdog on cycles with no transaction
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_ch.valid || merged_expect.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // random well-formed runs: loads then a start, with some noise
   task automatic random_runs(int n_items);
      int sent, nl;
      sent = 0;
      while (sent < n_items) begin
         nl = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
         repeat (nl) begin
            case ($urandom_range(0, 19))
               0: pending_reqs.push_back(make_req(KIND_IGNORED, 16'($urandom),
                                                  16'($urandom), $urandom));
               default: pending_reqs.push_back(rand_load(2'($urandom_range(0, 1))));
            endcase
            sent++;
         end
         pending_reqs.push_back(rand_load(KIND_START));
         sent++;
      end
   endtask

   initial begin
      int k;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      dropped_load = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: empty start, extremes, saturation, duplicates, ignored kind
      pending_reqs.push_back(make_req(KIND_START, 16'h0, 16'h0, 32'h0));
      pending_reqs.push_back(make_req(KIND_LOAD_A, 16'hffff, 16'hffff, 32'h7fffffff));
      pending_reqs.push_back(make_req(KIND_LOAD_B, 16'hffff, 16'hffff, 32'h00000001));
      pending_reqs.push_back(make_req(KIND_LOAD_A, 16'h0, 16'h0, 32'h80000000));
      pending_reqs.push_back(make_req(KIND_LOAD_B, 16'h0, 16'h0, 32'hffffffff));
      pending_reqs.push_back(make_req(KIND_LOAD_A, 16'h5, 16'h7, 32'h00010000));
      pending_reqs.push_back(make_req(KIND_LOAD_A, 16'h5, 16'h7, 32'h00020000));
      pending_reqs.push_back(make_req(KIND_LOAD_B, 16'h5, 16'h7, 32'h00030000));
      pending_reqs.push_back(make_req(KIND_LOAD_B, 16'h4, 16'hffff, 32'h12345678));
      pending_reqs.push_back(make_req(KIND_IGNORED, 16'hffff, 16'hffff, 32'hffffffff));
      pending_reqs.push_back(make_req(KIND_START, 16'hffff, 16'hffff, 32'hffffffff));
      pending_reqs.push_back(make_req(KIND_LOAD_B, 16'h1, 16'h1, 32'h0));
      pending_reqs.push_back(make_req(KIND_START, 16'h0, 16'h0, 32'h0));
      wait_drained();

      // fill list A past its depth while the receiver is held off
      for (k = 0; k < LIST_DEPTH + 2; k++)
         pending_reqs.push_back(make_req(KIND_LOAD_A, 16'(LIST_DEPTH - k), 16'(k),
                                         32'(k)));
      pending_reqs.push_back(make_req(KIND_START, 16'h0, 16'h0, 32'h0));
      for (k = 0; k < 20; k++)
         pending_reqs.push_back(rand_load(2'($urandom_range(0, 1))));
      pending_reqs.push_back(make_req(KIND_START, 16'h0, 16'h0, 32'h0));
      @(negedge clock) hold_off_cycles = 400;
      wait_drained();

      // random phases
      for (int p = 0; p < 4; p++) begin
         phase = phase_type'(p);
         random_runs(45);
         drain_pause = 1'b1;
         random_runs(35);
         wait_drained();
         phase = PH_FREE;
      end

      if (mismatches == 0 && merged_expect.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
